[rtl/aesr_pkg.sv]
// Shared types, S-box table and field helper for the AES round lane.
`default_nettype none

package aesr_pkg;

  // One input transaction: a state lane, its round key, a lane tag and the round mode.
  typedef struct packed {
    logic        mode;
    logic [1:0]  lane_in;
    logic [63:0] block_lo;
    logic [63:0] block_hi;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  lane_out;
    logic [63:0] result_lo;
    logic [63:0] result_hi;
  } out_t;

  localparam logic MODE_FULL = 1'b0;
  localparam logic MODE_LAST = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Multiply by x in GF(2^8) with the AES reduction polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

`default_nettype wire

[rtl/aesr_round.sv]
// Combinational AES encryption round: ShiftRows, SubBytes, MixColumns (skipped in last-round mode) and key add.
`default_nettype none

module aesr_round (
  input  aesr_pkg::in_t  src,
  output aesr_pkg::out_t dst
);
  import aesr_pkg::*;

  logic [7:0] st   [16];
  logic [7:0] key  [16];
  logic [7:0] sb   [16];
  logic [7:0] mc   [16];
  logic [7:0] res  [16];
  logic [7:0] colx [4];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      st[i]      = src.block_lo[8*i +: 8];
      st[i + 8]  = src.block_hi[8*i +: 8];
      key[i]     = src.key_lo[8*i +: 8];
      key[i + 8] = src.key_hi[8*i +: 8];
    end

    // Row r of the output column c comes from column (c + r) mod 4.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4*c] = SBOX[st[r + 4*((c + r) & 3)]];
      end
    end

    for (int c = 0; c < 4; c++) begin
      colx[c] = sb[4*c] ^ sb[4*c + 1] ^ sb[4*c + 2] ^ sb[4*c + 3];
      for (int r = 0; r < 4; r++) begin
        mc[4*c + r] = sb[4*c + r] ^ colx[c]
                    ^ xtime(sb[4*c + r] ^ sb[4*c + ((r + 1) & 3)]);
      end
    end

    for (int i = 0; i < 16; i++) begin
      res[i] = ((src.mode == MODE_LAST) ? sb[i] : mc[i]) ^ key[i];
    end

    dst.lane_out = src.lane_in;
    for (int i = 0; i < 8; i++) begin
      dst.result_lo[8*i +: 8] = res[i];
      dst.result_hi[8*i +: 8] = res[i + 8];
    end
  end

endmodule

`default_nettype wire

[rtl/aes_encrypt_round_lane.sv]
// Top level of the AES encryption round lane: input register, round logic, result register.
// An accepted transaction is captured in the input register, passes the round logic and is
// captured in the result register once that register is free.
// Throughput: one transaction per cycle while results are taken; one pass of logic per round.
// Reset (rst, synchronous, active high) empties both register stages; payload is not cleared.
`default_nettype none

module aes_encrypt_round_lane (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  aesr_pkg::in_t  item,
  output logic           result_valid,
  input  logic           result_ready,
  output aesr_pkg::out_t result
);
  import aesr_pkg::*;

  // The input register holds one captured transaction. It moves on whenever the
  // result register is empty or its contents are being taken in the same cycle,
  // so a waiting result blocks a new transaction only once the input register
  // is occupied as well.
  logic  stage_valid;
  in_t   stage;
  out_t  round_out;
  logic  out_free;
  logic  stage_free;

  assign out_free   = !result_valid || result_ready;
  assign stage_free = !stage_valid || out_free;
  assign item_ready = stage_free;

  // All of the round work sits between the two registers.
  aesr_round u_round (
    .src (stage),
    .dst (round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_free) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_free && item_valid) begin
      stage <= item;
    end
  end

  // The result register holds its transaction until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_valid) begin
      result <= round_out;
    end
  end

endmodule

`default_nettype wire

[rtl/aesr_checker.sv]
// Port-level checks for the AES round lane and the bind that attaches them.
`default_nettype none

module aesr_checker (
  input logic           clk,
  input logic           rst,
  input logic           item_valid,
  input logic           item_ready,
  input logic           result_valid,
  input logic           result_ready,
  input aesr_pkg::out_t result
);
  import aesr_pkg::*;

  // A stalled result keeps its valid and payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // With no result waiting, the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with empty output");

  // After an accepted transaction has moved through the input register, a valid result is present.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |-> ##2 result_valid)
    else $error("result missing two cycles after acceptance");

endmodule

bind aes_encrypt_round_lane aesr_checker u_aesr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
